// ===== rtl/core/psga_pkg.sv =====
// ----------------------------------------------------------------------------
// psga_pkg
// Shared constants and controller/datapath handshake types for the
// preferred-slot grid allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package psga_pkg;

    localparam int MAX_SLOTS_DEF     = 8;
    localparam int MAX_POSITIONS_DEF = 8;

    // register file
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITIONS_IN_USE = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  CFG_RESET_COUNT      = 4'd5;

    // count width covers a grid dimension of up to 16
    localparam int CNT_W = 5;

    // result codes
    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_MOVED   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    typedef struct packed {
        logic latch;
        logic do_check;
        logic do_scan;
        logic load_out;
    } psga_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic want_free;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } psga_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/psga_ctrl.sv =====
// ----------------------------------------------------------------------------
// psga_ctrl
// Sequencer: accept, check the wanted cell, scan rows, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module psga_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire psga_pkg::psga_sts_t  sts,
    output psga_pkg::psga_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_POST  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.do_check = 1'b1;
                if (sts.is_clear || sts.want_free)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.do_scan = 1'b1;
                if (sts.scan_hit || sts.scan_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                // wait for the output register to drain
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/psga_dpath.sv =====
// ----------------------------------------------------------------------------
// psga_dpath
// Occupancy rows, config registers, request latch, row scan and result
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psga_dpath
#(
    parameter int MAX_SLOTS     = psga_pkg::MAX_SLOTS_DEF,
    parameter int MAX_POSITIONS = psga_pkg::MAX_POSITIONS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psga_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [psga_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              req_type,
    input  wire logic [7:0]                        item_id,
    input  wire logic signed [7:0]                 want_slot,
    input  wire logic signed [7:0]                 want_position,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             status,
    output logic [7:0]                             item_echo,
    output logic [2:0]                             got_slot,
    output logic [2:0]                             got_position,
    input  wire psga_pkg::psga_cmd_t               cmd,
    output psga_pkg::psga_sts_t                    sts
);

    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW    = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CNT_W = psga_pkg::CNT_W;

    logic [psga_pkg::CFG_DATA_W-1:0] slots_cfg_reg;
    logic [psga_pkg::CFG_DATA_W-1:0] positions_cfg_reg;

    logic [MAX_POSITIONS-1:0] occ_reg [MAX_SLOTS];

    logic          clear_reg;
    logic [7:0]    item_reg;
    logic [SW-1:0] want_row_reg;
    logic [PW-1:0] want_col_reg;
    logic [SW-1:0] scan_row_reg;

    logic [1:0]    res_status_reg;
    logic [SW-1:0] res_row_reg;
    logic [PW-1:0] res_col_reg;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [7:0]    out_item_reg;
    logic [2:0]    out_slot_reg;
    logic [2:0]    out_pos_reg;

    logic [CNT_W-1:0]         rows_eff;
    logic [CNT_W-1:0]         cols_eff;
    logic [SW-1:0]            last_row;
    logic [PW-1:0]            last_col;
    logic [SW-1:0]            clamp_row;
    logic [PW-1:0]            clamp_col;
    logic [SW-1:0]            rd_row;
    logic [MAX_POSITIONS-1:0] row_data;
    logic [MAX_POSITIONS-1:0] col_mask;
    logic [MAX_POSITIONS-1:0] free_bits;
    logic                     hit;
    logic [PW-1:0]            hit_col;

    // zero counts as one, anything past the grid counts as the grid size
    always_comb
    begin
        if (slots_cfg_reg == '0)
        begin
            rows_eff = CNT_W'(1);
        end
        else if ({1'b0, slots_cfg_reg} > CNT_W'(MAX_SLOTS))
        begin
            rows_eff = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            rows_eff = {1'b0, slots_cfg_reg};
        end

        if (positions_cfg_reg == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if ({1'b0, positions_cfg_reg} > CNT_W'(MAX_POSITIONS))
        begin
            cols_eff = CNT_W'(MAX_POSITIONS);
        end
        else
        begin
            cols_eff = {1'b0, positions_cfg_reg};
        end
    end

    assign last_row = SW'(rows_eff - CNT_W'(1));
    assign last_col = PW'(cols_eff - CNT_W'(1));

    // negative or out-of-range coordinates go to the last in-use line
    always_comb
    begin
        if (want_slot[7] || ({1'b0, want_slot[6:0]} >= 8'(rows_eff)))
        begin
            clamp_row = last_row;
        end
        else
        begin
            clamp_row = SW'(want_slot[6:0]);
        end

        if (want_position[7] || ({1'b0, want_position[6:0]} >= 8'(cols_eff)))
        begin
            clamp_col = last_col;
        end
        else
        begin
            clamp_col = PW'(want_position[6:0]);
        end
    end

    // one row read per cycle, shared by the check and the scan
    assign rd_row   = cmd.do_scan ? scan_row_reg : want_row_reg;
    assign row_data = occ_reg[rd_row];

    always_comb
    begin
        for (int j = 0; j < MAX_POSITIONS; j++)
        begin
            col_mask[j] = (CNT_W'(j) < cols_eff);
        end
    end

    assign free_bits = ~row_data & col_mask;

    always_comb
    begin
        hit     = 1'b0;
        hit_col = '0;
        for (int j = MAX_POSITIONS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                hit     = 1'b1;
                hit_col = PW'(j);
            end
        end
    end

    assign sts.is_clear  = clear_reg;
    assign sts.want_free = !row_data[want_col_reg];
    assign sts.scan_hit  = hit;
    assign sts.scan_last = (scan_row_reg == last_row);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_cfg_reg     <= psga_pkg::CFG_RESET_COUNT;
            positions_cfg_reg <= psga_pkg::CFG_RESET_COUNT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psga_pkg::CFG_SLOTS_IN_USE:
                begin
                    slots_cfg_reg <= cfg_data;
                end
                psga_pkg::CFG_POSITIONS_IN_USE:
                begin
                    positions_cfg_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // occupancy bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                occ_reg[i] <= '0;
            end
        end
        else if (cmd.do_check && clear_reg)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                occ_reg[i] <= '0;
            end
        end
        else if (cmd.do_check && sts.want_free)
        begin
            occ_reg[rd_row][want_col_reg] <= 1'b1;
        end
        else if (cmd.do_scan && hit)
        begin
            occ_reg[rd_row][hit_col] <= 1'b1;
        end
    end

    // request latch, scan row and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            clear_reg    <= req_type;
            item_reg     <= item_id;
            want_row_reg <= clamp_row;
            want_col_reg <= clamp_col;
        end

        if (cmd.do_check)
        begin
            scan_row_reg <= '0;
            if (clear_reg)
            begin
                res_status_reg <= psga_pkg::ST_CLEARED;
                res_row_reg    <= '0;
                res_col_reg    <= '0;
            end
            else if (sts.want_free)
            begin
                res_status_reg <= psga_pkg::ST_PLACED;
                res_row_reg    <= want_row_reg;
                res_col_reg    <= want_col_reg;
            end
        end
        else if (cmd.do_scan)
        begin
            if (hit)
            begin
                res_status_reg <= psga_pkg::ST_MOVED;
                res_row_reg    <= scan_row_reg;
                res_col_reg    <= hit_col;
            end
            else if (sts.scan_last)
            begin
                res_status_reg <= psga_pkg::ST_FULL;
                res_row_reg    <= '0;
                res_col_reg    <= '0;
            end
            else
            begin
                scan_row_reg <= scan_row_reg + SW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_item_reg   <= clear_reg ? 8'd0 : item_reg;
            out_slot_reg   <= 3'(res_row_reg);
            out_pos_reg    <= 3'(res_col_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign item_echo    = out_item_reg;
    assign got_slot     = out_slot_reg;
    assign got_position = out_pos_reg;

endmodule

`default_nettype wire

// ===== rtl/core/preferred_slot_grid_allocator.sv =====
// ----------------------------------------------------------------------------
// preferred_slot_grid_allocator
// Places items in a grid of slots by positions, preferring the wanted cell
// and falling back to the first free cell in row-major order.
// ----------------------------------------------------------------------------
// A request is taken on in_valid/in_ready and yields exactly one result on
// out_valid/out_ready. A clear, or a place whose wanted cell is free, passes
// through the accept state, a state to check the wanted cell and a state that
// loads the result register. A place whose wanted cell is taken then also
// scans one in-use row per cycle through the single row-read port of the
// occupancy store, examining at most the number of rows in use after a zero
// count is taken as one and a count past the grid as the grid size. The load
// waits while the output register still holds a result that has not been
// taken. The next request is accepted in the cycle after the load, even if
// that result has not been taken yet. Config writes are always ready and
// should be issued only while no request is in flight.
`default_nettype none

module preferred_slot_grid_allocator
#(
    parameter int MAX_SLOTS     = psga_pkg::MAX_SLOTS_DEF,
    parameter int MAX_POSITIONS = psga_pkg::MAX_POSITIONS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psga_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [psga_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [7:0]                        item_id,
    input  wire logic signed [7:0]                 want_slot,
    input  wire logic signed [7:0]                 want_position,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             status,
    output logic [7:0]                             item_echo,
    output logic [2:0]                             got_slot,
    output logic [2:0]                             got_position
);

    psga_pkg::psga_cmd_t cmd;
    psga_pkg::psga_sts_t sts;

    psga_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psga_dpath
    #(
        .MAX_SLOTS     (MAX_SLOTS),
        .MAX_POSITIONS (MAX_POSITIONS)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .item_id       (item_id),
        .want_slot     (want_slot),
        .want_position (want_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .item_echo     (item_echo),
        .got_slot      (got_slot),
        .got_position  (got_position),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

// ===== sim/psga_result_monitor.sv =====
// ----------------------------------------------------------------------------
// psga_result_monitor
// Watches the register, request and result channels of the grid allocator,
// keeps its own occupancy grid, predicts each result and compares it.
// ----------------------------------------------------------------------------
module psga_result_monitor
    import psga_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   req_type,
    input  logic [7:0]             item_id,
    input  logic signed [7:0]      want_slot,
    input  logic signed [7:0]      want_position,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [1:0]             status,
    input  logic [7:0]             item_echo,
    input  logic [2:0]             got_slot,
    input  logic [2:0]             got_position,
    output int                     mismatches,
    output int                     in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] item;
        logic [2:0] slot;
        logic [2:0] position;
    } grant_t;

    logic [CFG_DATA_W-1:0] rows_reg;
    logic [CFG_DATA_W-1:0] cols_reg;
    bit                    occ [MAX_SLOTS_DEF][MAX_POSITIONS_DEF];
    grant_t                pending_grants[$];
    int                    fail_cnt = 0;

    function automatic int usable_count(logic [CFG_DATA_W-1:0] regval, int limit);
        if (regval == 0)
            return 1;
        if (regval > limit)
            return limit;
        return regval;
    endfunction

    function automatic int clamp_coord(logic signed [7:0] want, int count);
        if (want < 0 || int'(want) >= count)
            return count - 1;
        return want;
    endfunction

    // updates the grid and returns the grant for one request
    function automatic grant_t allocate_cell(logic clear, logic [7:0] id,
                                             logic signed [7:0] ws,
                                             logic signed [7:0] wp);
        grant_t g;
        int     nrows;
        int     ncols;
        int     r;
        int     c;
        bit     found;
        g     = '0;
        nrows = usable_count(rows_reg, MAX_SLOTS_DEF);
        ncols = usable_count(cols_reg, MAX_POSITIONS_DEF);
        if (clear)
        begin
            occ      = '{default: 1'b0};
            g.status = ST_CLEARED;
            return g;
        end
        g.item = id;
        r = clamp_coord(ws, nrows);
        c = clamp_coord(wp, ncols);
        if (!occ[r][c])
        begin
            occ[r][c]  = 1'b1;
            g.status   = ST_PLACED;
            g.slot     = r[2:0];
            g.position = c[2:0];
            return g;
        end
        // wanted cell taken: first free cell in row-major order
        g.status = ST_FULL;
        found    = 1'b0;
        for (r = 0; r < nrows && !found; r++)
        begin
            for (c = 0; c < ncols && !found; c++)
            begin
                if (!occ[r][c])
                begin
                    occ[r][c]  = 1'b1;
                    g.status   = ST_MOVED;
                    g.slot     = r[2:0];
                    g.position = c[2:0];
                    found      = 1'b1;
                end
            end
        end
        return g;
    endfunction

    task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
            fail_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t fresh;
        if (!rst_n)
        begin
            rows_reg = CFG_RESET_COUNT;
            cols_reg = CFG_RESET_COUNT;
            occ      = '{default: 1'b0};
            pending_grants.delete();
            in_flight  <= 0;
            mismatches <= fail_cnt;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SLOTS_IN_USE)
                    rows_reg = cfg_data;
                else if (cfg_index == CFG_POSITIONS_IN_USE)
                    cols_reg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d item %0d slot %0d pos %0d",
                             $time, status, item_echo, got_slot, got_position);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    check_field("status", want.status, status);
                    check_field("item_echo", want.item, item_echo);
                    check_field("got_slot", want.slot, got_slot);
                    check_field("got_position", want.position, got_position);
                end
            end
            if (in_valid && in_ready)
            begin
                fresh = allocate_cell(req_type, item_id, want_slot, want_position);
                pending_grants = {pending_grants, fresh};
            end
            in_flight  <= pending_grants.size();
            mismatches <= fail_cnt;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the grid allocator with directed corner requests and random place
// and clear traffic over several grid sizes and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psga_pkg::*;

    localparam logic                   REQ_PLACE       = 1'b0;
    localparam logic                   REQ_CLEAR       = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLE_INDEX  = 2'd2;
    localparam int                     ITEMS_PER_PHASE = 62;
    localparam int                     DRAIN_CYCLES    = 20;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   req_type = 1'b0;
    logic [7:0]             item_id = '0;
    logic signed [7:0]      want_slot = '0;
    logic signed [7:0]      want_position = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_ready;
    logic                   in_ready;
    logic                   out_valid;
    logic [1:0]             status;
    logic [7:0]             item_echo;
    logic [2:0]             got_slot;
    logic [2:0]             got_position;
    int                     mismatches;
    int                     in_flight;

    int idle_pct  = 0;
    int stall_pct = 0;

    preferred_slot_grid_allocator dut (.*);

    psga_result_monitor monitor (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_req(logic kind, logic [7:0] id, logic signed [7:0] ws,
                            logic signed [7:0] wp);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        item_id       <= id;
        want_slot     <= ws;
        want_position <= wp;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic place(logic [7:0] id, logic signed [7:0] ws, logic signed [7:0] wp);
        send_req(REQ_PLACE, id, ws, wp);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_grid(int rows, int cols);
        wait_drained();
        write_reg(CFG_SLOTS_IN_USE, rows[CFG_DATA_W-1:0]);
        write_reg(CFG_POSITIONS_IN_USE, cols[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // mostly in-range cells; clears get rarer as the grid grows so it fills up
    task automatic random_req(int r_eff, int c_eff);
        logic signed [7:0] ws;
        logic signed [7:0] wp;
        ws = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(r_eff - 1));
        wp = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(c_eff - 1));
        if ($urandom_range(r_eff * c_eff + 4) == 0)
            send_req(REQ_CLEAR, 8'($urandom), ws, wp);
        else
            place(8'($urandom), ws, wp);
    endtask

    initial
    begin
        int grid_rows [8] = '{3, 8, 1, 8, 0, 2, 15, 6};
        int grid_cols [8] = '{4, 8, 8, 1, 15, 2, 0, 7};
        int r_eff;
        int c_eff;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid of 5 by 5
        place(8'd1, 8'sd0, 8'sd0);
        place(8'd2, 8'sd0, 8'sd0);
        place(8'd0, 8'sd4, 8'sd4);
        place(8'hFF, -8'sd128, -8'sd1);
        place(8'h80, 8'sd127, 8'sd127);
        place(8'h7F, 8'sd5, 8'sd5);
        place(8'h55, -8'sd1, 8'sd0);
        send_req(REQ_CLEAR, 8'hAA, 8'sd127, -8'sd128);
        place(8'h01, 8'sd2, 8'sd3);

        // zero counts act as a single cell
        set_grid(0, 0);
        place(8'h10, 8'sd3, -8'sd3);
        place(8'h11, 8'sd0, 8'sd0);
        place(8'h00, 8'sd0, 8'sd0);

        // writes to unused indexes change nothing
        wait_drained();
        write_reg(CFG_SPARE_INDEX, 4'hF);
        write_reg(CFG_HOLE_INDEX, 4'h0);
        cfg_valid <= 1'b0;
        place(8'h12, 8'sd0, 8'sd0);

        // counts past the grid limit
        set_grid(15, 9);
        place(8'h20, 8'sd7, 8'sd7);
        place(8'h21, 8'sd100, 8'sd100);
        place(8'h22, 8'sd8, -8'sd2);

        // shrink: cells outside keep their bits
        set_grid(2, 2);
        place(8'h23, 8'sd1, 8'sd1);
        place(8'h24, 8'sd1, 8'sd1);
        place(8'h25, 8'sd0, 8'sd0);
        send_req(REQ_CLEAR, 8'h00, 8'sd0, 8'sd0);

        for (int p = 0; p < 8; p++)
        begin
            case (p / 2)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            set_grid(grid_rows[p], grid_cols[p]);
            r_eff = (grid_rows[p] == 0) ? 1 : (grid_rows[p] > 8 ? 8 : grid_rows[p]);
            c_eff = (grid_cols[p] == 0) ? 1 : (grid_cols[p] > 8 ? 8 : grid_cols[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // let everything drain mid-phase now and then
                if (p % 2 == 1 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                random_req(r_eff, c_eff);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
